// ===== rtl/yuvpk_pkg.sv =====
// Shared types and constants for the RGB pair to packed 4:2:2 converter.
// Holds the BT.601 weights in thousandths, lane stage controls and byte codes.
// No dependencies.
package yuvpk_pkg;

    typedef logic [7:0] t_byte;
    typedef logic signed [9:0] t_coef;
    typedef logic signed [18:0] t_prod;
    typedef logic signed [19:0] t_acc;
    typedef logic [17:0] t_sum;

    typedef struct packed {
        t_coef       w_red;
        t_coef       w_green;
        t_coef       w_blue;
        logic [16:0] offset;
    } t_coef_set;

    // Weights in units of 1/1000, offset already scaled by 1000
    localparam t_coef_set COEF_LUMA = '{
        w_red: 10'sd257, w_green: 10'sd504, w_blue: 10'sd98, offset: 17'd16000};
    localparam t_coef_set COEF_CB = '{
        w_red: -10'sd148, w_green: -10'sd291, w_blue: 10'sd439, offset: 17'd128000};
    localparam t_coef_set COEF_CR = '{
        w_red: 10'sd439, w_green: -10'sd368, w_blue: -10'sd71, offset: 17'd128000};

    // Floor division by 1000: multiply by 1048 / 2^20 (one low at most), then fix up
    localparam int SCALE       = 1000;
    localparam int RECIP       = 1048;
    localparam int RECIP_SHIFT = 20;
    localparam int EST_W       = 18 + 11;

    localparam logic ORDER_YUY2 = 1'b0;
    localparam logic ORDER_UYVY = 1'b1;

    localparam t_byte BYTE_MIN = 8'd16;
    localparam t_byte BYTE_MAX = 8'd239;

    typedef struct packed {
        logic s1_en;
        logic s2_en;
        logic s3_en;
        logic s4_en;
    } t_stage_ctl;

    typedef struct packed {
        t_byte byte_zero;
        t_byte byte_one;
        t_byte byte_two;
        t_byte byte_three;
    } t_packed_out;

endpackage

// ===== rtl/yuvpk_if.sv =====
// Channel interfaces of the converter: pixel pair in, packed bytes out, mode write.
// Depends on yuvpk_pkg.
interface yuvpk_pix_if;
    import yuvpk_pkg::*;
    logic  valid;
    logic  ready;
    t_byte red_first;
    t_byte green_first;
    t_byte blue_first;
    t_byte red_second;
    t_byte green_second;
    t_byte blue_second;

    modport source (output valid, red_first, green_first, blue_first,
                    red_second, green_second, blue_second, input ready);
    modport sink (input valid, red_first, green_first, blue_first,
                  red_second, green_second, blue_second, output ready);
endinterface

interface yuvpk_yuv_if;
    import yuvpk_pkg::*;
    logic  valid;
    logic  ready;
    t_byte packed_byte_zero;
    t_byte packed_byte_one;
    t_byte packed_byte_two;
    t_byte packed_byte_three;

    modport source (output valid, packed_byte_zero, packed_byte_one, packed_byte_two,
                    packed_byte_three, input ready);
    modport sink (input valid, packed_byte_zero, packed_byte_one, packed_byte_two,
                  packed_byte_three, output ready);
endinterface

interface yuvpk_cfg_if;
    logic valid;
    logic ready;
    logic packing_order;

    modport source (output valid, packing_order, input ready);
    modport sink (input valid, packing_order, output ready);
endinterface

// ===== rtl/yuvpk_lane.sv =====
// One conversion lane: three weighted products, sum with offset, floor divide by 1000.
// Four register stages, each loaded by its enable. Depends on yuvpk_pkg.
module yuvpk_lane (
    input  logic                   i_clk,
    input  yuvpk_pkg::t_stage_ctl  i_ctl,
    input  yuvpk_pkg::t_coef_set   i_coef,
    input  yuvpk_pkg::t_byte       i_red,
    input  yuvpk_pkg::t_byte       i_green,
    input  yuvpk_pkg::t_byte       i_blue,
    output yuvpk_pkg::t_byte       o_value
);
    import yuvpk_pkg::*;

    t_prod             r_prod_r, r_prod_g, r_prod_b;
    t_prod             n_prod_r, n_prod_g, n_prod_b;
    t_acc              n_acc;
    t_sum              r_sum, r_sum_d;
    logic [EST_W-1:0]  n_est;
    logic [8:0]        r_q_est;
    t_sum              n_q_scaled;
    t_sum              n_rem;
    logic [8:0]        n_quot;
    t_byte             r_value;

    always_comb begin
        n_prod_r = t_prod'($signed({1'b0, i_red}))   * t_prod'(i_coef.w_red);
        n_prod_g = t_prod'($signed({1'b0, i_green})) * t_prod'(i_coef.w_green);
        n_prod_b = t_prod'($signed({1'b0, i_blue}))  * t_prod'(i_coef.w_blue);
        // Sum is never negative once the offset is in
        n_acc = t_acc'(r_prod_r) + t_acc'(r_prod_g) + t_acc'(r_prod_b)
              + t_acc'($signed({1'b0, i_coef.offset}));
        n_est = EST_W'(r_sum) * EST_W'(RECIP);
        n_q_scaled = t_sum'({9'b0, r_q_est} * t_sum'(SCALE));
        n_rem = r_sum_d - n_q_scaled;
        // Estimate is at most one low: bump it when the remainder reaches 1000
        n_quot = (n_rem >= t_sum'(SCALE)) ? r_q_est + 9'd1 : r_q_est;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s1_en) begin
            r_prod_r <= n_prod_r;
            r_prod_g <= n_prod_g;
            r_prod_b <= n_prod_b;
        end
        if (i_ctl.s2_en) begin
            r_sum <= n_acc[17:0];
        end
        if (i_ctl.s3_en) begin
            r_sum_d <= r_sum;
            r_q_est <= n_est[RECIP_SHIFT +: 9];
        end
        if (i_ctl.s4_en) begin
            r_value <= n_quot[7:0];
        end
    end

    assign o_value = r_value;

endmodule

// ===== rtl/yuvpk_merge.sv =====
// Output stage: places the four lane results in YUY2 or UYVY byte order and holds them.
// Depends on yuvpk_pkg.
module yuvpk_merge (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic                    i_order,
    input  yuvpk_pkg::t_byte        i_luma_first,
    input  yuvpk_pkg::t_byte        i_cb,
    input  yuvpk_pkg::t_byte        i_luma_second,
    input  yuvpk_pkg::t_byte        i_cr,
    output yuvpk_pkg::t_packed_out  o_bytes
);
    import yuvpk_pkg::*;

    t_packed_out r_bytes;
    t_packed_out n_bytes;

    always_comb begin
        case (i_order)
            ORDER_YUY2: begin
                n_bytes = '{byte_zero: i_luma_first, byte_one: i_cb,
                            byte_two: i_luma_second, byte_three: i_cr};
            end
            ORDER_UYVY: begin
                n_bytes = '{byte_zero: i_cb, byte_one: i_luma_first,
                            byte_two: i_cr, byte_three: i_luma_second};
            end
            default: begin
                n_bytes = '{byte_zero: i_luma_first, byte_one: i_cb,
                            byte_two: i_luma_second, byte_three: i_cr};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bytes <= n_bytes;
        end
    end

    assign o_bytes = r_bytes;

endmodule

// ===== rtl/rgb_pair_to_yuv422_packer_unit.sv =====
// Top level of the RGB pair to packed 4:2:2 converter.
// Depends on yuvpk_pkg, the yuvpk interfaces, yuvpk_lane and yuvpk_merge.
//
// Takes one pair of 8-bit RGB pixels per transaction and returns four packed bytes
// (YUY2: Y0 Cb Y1 Cr, UYVY: Cb Y0 Cr Y1, chosen by the one-bit mode register).
// Four lanes (Y0, Cb, Y1, Cr) run side by side; each is four stages deep (products,
// sum, reciprocal multiply, remainder fix-up) and a merge stage orders the bytes, so a
// result passes five registered stages. One pair is accepted every cycle unless stage
// one is held; each stage holds its item only while the stage after it is full and
// stalled, so a waiting result does not block the pairs behind it until all are full.
// Write the mode only while no pair is in flight.
module rgb_pair_to_yuv422_packer_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    yuvpk_pix_if.sink     i_pix,
    yuvpk_cfg_if.sink     i_cfg,
    yuvpk_yuv_if.source   o_yuv
);
    import yuvpk_pkg::*;

    logic        r_order;
    logic        r_v1, r_v2, r_v3, r_v4, r_v5;
    logic        adv1, adv2, adv3, adv4, adv5;
    t_stage_ctl  lane_ctl;
    t_byte       luma_first, luma_second, chroma_b, chroma_r;
    t_packed_out out_bytes;

    // A stage moves when it is empty or the one after it moves
    assign adv5 = !r_v5 || o_yuv.ready;
    assign adv4 = !r_v4 || adv5;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    assign lane_ctl = '{s1_en: adv1, s2_en: adv2, s3_en: adv3, s4_en: adv4};

    assign i_pix.ready = adv1;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_YUY2;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_order <= i_cfg.packing_order;
            end
            if (adv1) begin
                r_v1 <= i_pix.valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
            if (adv4) begin
                r_v4 <= r_v3;
            end
            if (adv5) begin
                r_v5 <= r_v4;
            end
        end
    end

    yuvpk_lane u_lane_y0 (
        .i_clk   (i_clk),
        .i_ctl   (lane_ctl),
        .i_coef  (COEF_LUMA),
        .i_red   (i_pix.red_first),
        .i_green (i_pix.green_first),
        .i_blue  (i_pix.blue_first),
        .o_value (luma_first)
    );

    yuvpk_lane u_lane_cb (
        .i_clk   (i_clk),
        .i_ctl   (lane_ctl),
        .i_coef  (COEF_CB),
        .i_red   (i_pix.red_first),
        .i_green (i_pix.green_first),
        .i_blue  (i_pix.blue_first),
        .o_value (chroma_b)
    );

    yuvpk_lane u_lane_y1 (
        .i_clk   (i_clk),
        .i_ctl   (lane_ctl),
        .i_coef  (COEF_LUMA),
        .i_red   (i_pix.red_second),
        .i_green (i_pix.green_second),
        .i_blue  (i_pix.blue_second),
        .o_value (luma_second)
    );

    yuvpk_lane u_lane_cr (
        .i_clk   (i_clk),
        .i_ctl   (lane_ctl),
        .i_coef  (COEF_CR),
        .i_red   (i_pix.red_second),
        .i_green (i_pix.green_second),
        .i_blue  (i_pix.blue_second),
        .o_value (chroma_r)
    );

    yuvpk_merge u_merge (
        .i_clk         (i_clk),
        .i_en          (adv5),
        .i_order       (r_order),
        .i_luma_first  (luma_first),
        .i_cb          (chroma_b),
        .i_luma_second (luma_second),
        .i_cr          (chroma_r),
        .o_bytes       (out_bytes)
    );

    assign o_yuv.valid             = r_v5;
    assign o_yuv.packed_byte_zero  = out_bytes.byte_zero;
    assign o_yuv.packed_byte_one   = out_bytes.byte_one;
    assign o_yuv.packed_byte_two   = out_bytes.byte_two;
    assign o_yuv.packed_byte_three = out_bytes.byte_three;

`ifndef SYNTHESIS
    a_out_from_stage4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v5) |-> $past(r_v4))
        else $error("output valid rose without a result in the last lane stage");

    a_full_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && !o_yuv.ready) |-> !i_pix.ready)
        else $error("pair accepted while every stage is full and stalled");

    a_bubble_takes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_v1 || !r_v2 || !r_v3 || !r_v4 || !r_v5 || o_yuv.ready) |-> i_pix.ready)
        else $error("input stalled although the pipeline has room");

    a_bytes_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> (out_bytes.byte_zero >= BYTE_MIN && out_bytes.byte_zero <= BYTE_MAX
               && out_bytes.byte_one >= BYTE_MIN && out_bytes.byte_one <= BYTE_MAX
               && out_bytes.byte_two >= BYTE_MIN && out_bytes.byte_two <= BYTE_MAX
               && out_bytes.byte_three >= BYTE_MIN && out_bytes.byte_three <= BYTE_MAX))
        else $error("packed byte outside the studio range");
`endif

endmodule
